[rtl/kss_pkg.sv]
// Shared constants and types for the k-th smallest stream selector.
`timescale 1ns / 1ps

package kss_pkg;

   localparam int K_MAX   = 64;
   localparam int DATA_W  = 32;
   localparam int RANK_W  = 7;
   localparam int CNT_W   = $clog2(K_MAX + 1);
   localparam int IDX_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int CMP_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

   typedef struct packed {
      logic                     ge;
      logic signed [DATA_W-1:0] value;
   } kss_link_type;

endpackage

[rtl/kss_cell.sv]
// One cell of the insertion chain: holds one kept value in sorted position.
`timescale 1ns / 1ps

module kss_cell
   import kss_pkg::*;
(
   input  logic                     clock,
   input  logic                     load,
   input  logic                     occupied,
   input  logic signed [DATA_W-1:0] sample,
   input  kss_link_type             prev_link,
   output kss_link_type             link
);

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     ge;

   // The new word goes at or below this cell when the cell is empty or holds a larger value.
   assign ge = !occupied || (value_ff > sample);

   always_comb begin
      value_in = value_ff;
      if (prev_link.ge) begin
         value_in = prev_link.value;
      end else if (ge) begin
         value_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
      end
   end

   assign link.ge    = ge;
   assign link.value = value_ff;

endmodule

[rtl/kth_smallest_stream_selector.sv]
// Top level of the k-th smallest stream selector with its insertion cell chain.
`timescale 1ns / 1ps

// The request channel carries one signed sample per word and a last flag that closes a set.
// A row of cells keeps the smallest rank_k samples of the set in ascending order; every
// accepted word is compared against all cells at once and shifts the larger ones up by one
// cell, so a word that is not last is taken every cycle.
// After the last word of a set is accepted, req_stall is high while the largest kept value
// is read out of the chain into the response register; the last word sets busy_ff, and
// the response word is valid once the read-out has loaded that register.
// The response carries kth_value and short_set, which is high when fewer than rank_k samples
// arrived; kth_value is then the largest sample of the set.
// The response sits in an output register. While rsp_stall holds it, words of the next set
// are still taken, but the read-out of that set's result waits, with req_stall high, until
// the register is free.
// rank_k is written through csr_wr_en and csr_rank_k; zero acts as one and values above 64
// act as 64. A new rank applies from the next word on, also in the middle of a set.
// Synchronous reset empties the chain, drops any pending response and sets rank_k to one.

module kth_smallest_stream_selector
   import kss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [RANK_W-1:0]        csr_rank_k,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_sample,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_kth_value,
   output logic                     rsp_short_set
);

   logic [RANK_W-1:0]        rank_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic                     short_ff;
   logic                     short_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_short_ff;

   logic [CMP_W-1:0]         rank_wide;
   logic [CNT_W-1:0]         limit;
   logic [CNT_W-1:0]         count_clamped;
   logic                     req_accept;
   logic                     rsp_accept;
   logic                     rsp_load;
   logic                     inserted;
   logic [K_MAX-1:0]         ge_vec;
   logic [K_MAX-1:0]         lim_mask;
   logic [CNT_W-1:0]         rd_sum;
   logic [IDX_W-1:0]         rd_idx;

   kss_link_type             links [K_MAX];
   kss_link_type             cell_in [K_MAX];
   logic signed [DATA_W-1:0] kept [K_MAX];

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rank_wide = CMP_W'(rank_ff);
      if (rank_wide == '0) begin
         limit = CNT_W'(1);
      end else if (rank_wide > CMP_W'(K_MAX)) begin
         limit = CNT_W'(K_MAX);
      end else begin
         limit = CNT_W'(rank_wide);
      end
      count_clamped = (count_ff > limit) ? limit : count_ff;
   end

   for (genvar i = 0; i < K_MAX; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_POS = CNT_W'(i);

      if (i == 0) begin : g_head
         assign cell_in[i] = '{ge: 1'b0, value: '0};
      end else begin : g_body
         assign cell_in[i] = links[i-1];
      end

      kss_cell u_cell (
         .clock     (clock),
         .load      (req_accept),
         .occupied  (CELL_POS < count_clamped),
         .sample    (req_sample),
         .prev_link (cell_in[i]),
         .link      (links[i])
      );

      assign ge_vec[i]   = links[i].ge;
      assign lim_mask[i] = CELL_POS < limit;
      assign kept[i]     = links[i].value;
   end

   assign inserted = |(ge_vec & lim_mask);
   assign rd_sum   = count_ff - CNT_W'(1);
   assign rd_idx   = rd_sum[IDX_W-1:0];
   assign rsp_load = busy_ff && (!rsp_valid_ff || rsp_accept);

   always_comb begin
      count_in     = count_ff;
      busy_in      = busy_ff;
      short_in     = short_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         count_in = ((inserted && (count_clamped < limit)) ? count_clamped + CNT_W'(1)
                                                           : count_clamped);
         if (req_is_last) begin
            busy_in  = 1'b1;
            short_in = count_in < limit;
         end
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
         count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= RANK_RESET;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            rank_ff <= csr_rank_k;
         end
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      short_ff <= short_in;
      if (rsp_load) begin
         rsp_value_ff <= kept[rd_idx];
         rsp_short_ff <= short_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kth_value = rsp_value_ff;
   assign rsp_short_set = rsp_short_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(K_MAX))
      else $error("kept count exceeds chain length");

   a_last_blocks : assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_is_last) |=> busy_ff)
      else $error("last word did not start the read-out");

   a_rsp_from_busy : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response appeared without a finished set");

   a_clear_after_set : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (count_ff == '0))
      else $error("chain not emptied after read-out");

   a_busy_has_data : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (count_ff != '0))
      else $error("read-out with an empty chain");
`endif

endmodule
